// File: rtl/highpass_running_rms_two_axis_defines.svh
// assertion macros for the top-level rtl module
`ifndef HIGHPASS_RUNNING_RMS_TWO_AXIS_DEFINES_SVH
`define HIGHPASS_RUNNING_RMS_TWO_AXIS_DEFINES_SVH

// implication checked at each clock edge, disabled in reset
`define HPR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent, disabled in reset
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hprms_pkg.sv
package hprms_pkg;

  localparam int SampleBits = 24;
  localparam int CountBits  = 20;
  localparam int FiltBits   = 32;
  localparam int SqBits     = 64;
  localparam int CoefBits   = 16;
  localparam int StepBits   = 25;
  localparam int NumAxes    = 2;
  localparam logic [CoefBits-1:0] CoefReset = 16'd49152;

  // divide / root unit steps
  localparam int DivSteps   = SqBits;
  localparam int RootSteps  = SqBits / 2;
  localparam int StepCntBits = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_DIFF,
    ST_MEAN_DIV,
    ST_MEAN_UPD,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_VAR_DIV,
    ST_RMS_ROOT,
    ST_TOT_SQ,
    ST_TOT_ROOT,
    ST_DONE
  } hprms_state_t;

  // control from sequencer to each axis lane
  typedef struct packed {
    logic load;
    logic restart;
    logic first;
    logic filt;
    logic mean_upd;
    logic sq_mul;
    logic sq_acc;
  } lane_ctrl_t;

  function automatic logic signed [FiltBits-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) sat32 = hi[FiltBits-1:0];
    else if (v < lo) sat32 = lo[FiltBits-1:0];
    else sat32 = v[FiltBits-1:0];
  endfunction

endpackage

// File: rtl/hprms_if.sv
interface hprms_in_if import hprms_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  logic signed [SampleBits-1:0] ra_sample;
  logic signed [SampleBits-1:0] dec_sample;
  modport source (output valid, restart, ra_sample, dec_sample, input ready);
  modport sink (input valid, restart, ra_sample, dec_sample, output ready);
endinterface

interface hprms_out_if import hprms_pkg::*; ();
  logic valid;
  logic ready;
  logic [CountBits-1:0] sample_count;
  logic signed [SampleBits-1:0] ra_hp_mean;
  logic signed [SampleBits-1:0] dec_hp_mean;
  logic [SampleBits-1:0] ra_rms;
  logic [SampleBits-1:0] dec_rms;
  logic [SampleBits-1:0] total_rms;
  logic [SampleBits-1:0] ra_peak_step;
  logic [SampleBits-1:0] dec_peak_step;
  logic [SampleBits-1:0] ra_peak_to_peak;
  modport source (output valid, sample_count, ra_hp_mean, dec_hp_mean, ra_rms, dec_rms,
    total_rms, ra_peak_step, dec_peak_step, ra_peak_to_peak, input ready);
  modport sink (input valid, sample_count, ra_hp_mean, dec_hp_mean, ra_rms, dec_rms,
    total_rms, ra_peak_step, dec_peak_step, ra_peak_to_peak, output ready);
endinterface

interface hprms_cfg_if import hprms_pkg::*; ();
  logic valid;
  logic ready;
  logic [CoefBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/highpass_running_rms_two_axis.sv
// two-axis guide error statistics with one-pole high-pass per axis
// channels: in (restart, ra_sample, dec_sample), out (nine statistics),
// cfg (16-bit high-pass coefficient, Q0.16, taken only while idle)
// each beat is handled alone: one beat in, one beat out
// each beat passes through one shared divide and root unit: four 64-step
// divides and three 32-step roots, in turn, plus filter, deviation, mean,
// square and total steps
// the two axis lanes run filter, mean and square updates side by side
// a new beat is taken only once the last result is accepted; in.ready is low while busy
// the result is held in an output register until out.ready; a stalled
// receiver holds the block in its done state and in.ready stays low
// reset loads the coefficient 0.75 and clears all statistics
module highpass_running_rms_two_axis import hprms_pkg::*; (
  input logic        clk,
  input logic        rst,
  hprms_in_if.sink   in,
  hprms_out_if.source out,
  hprms_cfg_if.sink  cfg
);

  `include "highpass_running_rms_two_axis_defines.svh"

  hprms_state_t state, state_next;
  logic [CoefBits-1:0]  coef;
  logic [CountBits-1:0] cnt;
  logic                 first;
  logic                 restart_q;
  logic signed [SampleBits-1:0] xs [NumAxes];
  logic [0:0]           job;
  logic                 div_start, root_start, busy;
  logic [SqBits-1:0]    dr_num, dr_res;
  logic [CountBits-1:0] dr_den;
  logic [SqBits-1:0]    quot [NumAxes];
  logic signed [FiltBits:0] d0 [NumAxes];
  logic [SqBits-1:0]    sqs [NumAxes];
  logic signed [FiltBits-1:0] mean [NumAxes];
  logic [StepBits-1:0]  peak [NumAxes];
  logic [SqBits-1:0]    rms_full [NumAxes];
  logic [SqBits-1:0]    tot_sum;
  logic signed [SampleBits-1:0] ra_min, ra_max;
  lane_ctrl_t           ctrl;
  logic                 started;

  assign cfg.ready = (state == ST_IDLE);
  assign in.ready = (state == ST_IDLE);

  // coefficient register
  always_ff @(posedge clk) begin
    if (rst) coef <= CoefReset;
    else if (cfg.valid && cfg.ready) coef <= cfg.data;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.first = first;
    ctrl.restart = restart_q;
    div_start = 1'b0; root_start = 1'b0;
    dr_num = '0; dr_den = cnt;
    unique case (state)
      ST_IDLE:     if (in.valid) state_next = ST_FILT;
      ST_FILT:     begin ctrl.filt = 1'b1; state_next = ST_DIFF; end
      ST_DIFF:     state_next = ST_MEAN_DIV;
      ST_MEAN_DIV: begin
        dr_num = {{(SqBits-FiltBits){1'b0}},
                  d0[job[0]][FiltBits] ? FiltBits'(-d0[job[0]]) : FiltBits'(d0[job[0]])}
                 + SqBits'(cnt >> 1);
        if (!started) div_start = 1'b1;
        else if (!busy) state_next = job[0] ? ST_MEAN_UPD : ST_MEAN_DIV;
      end
      ST_MEAN_UPD: begin ctrl.mean_upd = 1'b1; state_next = ST_SQ_MUL; end
      ST_SQ_MUL:   begin ctrl.sq_mul = 1'b1; state_next = ST_SQ_ACC; end
      ST_SQ_ACC:   begin ctrl.sq_acc = 1'b1; state_next = ST_VAR_DIV; end
      ST_VAR_DIV: begin
        dr_num = sqs[job[0]];
        if (!started) div_start = 1'b1;
        else if (!busy) state_next = job[0] ? ST_RMS_ROOT : ST_VAR_DIV;
      end
      ST_RMS_ROOT: begin
        dr_num = quot[job[0]];
        if (!started) root_start = 1'b1;
        else if (!busy) state_next = job[0] ? ST_TOT_SQ : ST_RMS_ROOT;
      end
      ST_TOT_SQ:   state_next = ST_TOT_ROOT;
      ST_TOT_ROOT: begin
        dr_num = tot_sum;
        if (!started) root_start = 1'b1;
        else if (!busy) state_next = ST_DONE;
      end
      ST_DONE:     if (out.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sample capture, count, job select and divider results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; first <= 1'b0; restart_q <= 1'b0; job <= '0; started <= 1'b0;
      ra_min <= '0; ra_max <= '0;
    end else begin
      if (state == ST_IDLE && in.valid) begin
        xs[0] <= in.ra_sample; xs[1] <= in.dec_sample;
        restart_q <= in.restart;
        first <= in.restart || (cnt == '0);
        if (in.restart) begin cnt <= '0; ra_min <= '0; ra_max <= '0; end
        job <= '0; started <= 1'b0;
      end
      if (state == ST_FILT) begin
        if (cnt != '1) cnt <= cnt + CountBits'(1);
        if (first || xs[0] < ra_min) ra_min <= xs[0];
        if (first || xs[0] > ra_max) ra_max <= xs[0];
      end
      if (div_start || root_start) started <= 1'b1;
      if (started && !busy && (state == ST_MEAN_DIV || state == ST_VAR_DIV ||
          state == ST_RMS_ROOT || state == ST_TOT_ROOT)) begin
        started <= 1'b0;
        job <= ~job;
        if (state == ST_MEAN_DIV || state == ST_VAR_DIV) quot[job[0]] <= dr_res;
        if (state == ST_RMS_ROOT) rms_full[job[0]] <= dr_res > 64'hFF_FFFF ? 64'hFF_FFFF : dr_res;
      end
      if (state == ST_TOT_SQ)
        tot_sum <= SqBits'(rms_full[0][SampleBits-1:0]) * SqBits'(rms_full[0][SampleBits-1:0])
                 + SqBits'(rms_full[1][SampleBits-1:0]) * SqBits'(rms_full[1][SampleBits-1:0]);
    end
  end

  hprms_divroot u_divroot (
    .clk, .rst, .start_div(div_start), .start_root(root_start),
    .num(dr_num), .den(dr_den), .busy, .result(dr_res)
  );

  // two axis lanes
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    lane_ctrl_t lc;
    always_comb begin
      lc = ctrl;
      lc.load = (state == ST_IDLE) && in.valid;
      lc.restart = in.restart;
    end
    hprms_lane u_lane (
      .clk, .rst, .ctrl(lc), .x(lc.load ? (a == 0 ? in.ra_sample : in.dec_sample) : xs[a]),
      .coef, .quot(quot[a]), .diff(d0[a]), .sq_sum(sqs[a]),
      .mean(mean[a]), .peak(peak[a])
    );
  end

  // output merge
  function automatic logic signed [SampleBits-1:0] osat(input logic signed [FiltBits-1:0] v);
    if (v > 32'sh007F_FFFF) osat = 24'sh7F_FFFF;
    else if (v < -32'sh0080_0000) osat = -24'sh80_0000;
    else osat = v[SampleBits-1:0];
  endfunction

  logic [SampleBits:0] p2p;
  assign p2p = (SampleBits+1)'(ra_max) - (SampleBits+1)'(ra_min);

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (state == ST_TOT_ROOT && started && !busy) out.valid <= 1'b1;
    else if (out.valid && out.ready) out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_TOT_ROOT && started && !busy) begin
      out.sample_count <= cnt;
      out.ra_hp_mean <= osat(mean[0]);
      out.dec_hp_mean <= osat(mean[1]);
      out.ra_rms <= rms_full[0][SampleBits-1:0];
      out.dec_rms <= rms_full[1][SampleBits-1:0];
      out.total_rms <= dr_res > 64'hFF_FFFF ? 24'hFF_FFFF : dr_res[SampleBits-1:0];
      out.ra_peak_step <= peak[0][SampleBits] ? 24'hFF_FFFF : peak[0][SampleBits-1:0];
      out.dec_peak_step <= peak[1][SampleBits] ? 24'hFF_FFFF : peak[1][SampleBits-1:0];
      out.ra_peak_to_peak <= p2p[SampleBits-1:0];
    end
  end

  `HPR_ASSERT(a_busy_out, out.valid, state == ST_DONE, "result shown outside done state")
  `HPR_ASSERT(a_no_in_busy, state != ST_IDLE, !in.ready, "input taken while busy")
  `HPR_ASSERT_NEXT(a_done_release, state == ST_DONE && out.ready, state == ST_IDLE,
    "done state not left after beat")

endmodule

// File: rtl/hprms_lane.sv
module hprms_lane import hprms_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  lane_ctrl_t                   ctrl,
  input  logic signed [SampleBits-1:0] x,
  input  logic [CoefBits-1:0]          coef,
  input  logic [SqBits-1:0]            quot,
  output logic signed [FiltBits:0]     diff,
  output logic [SqBits-1:0]            sq_sum,
  output logic signed [FiltBits-1:0]   mean,
  output logic [StepBits-1:0]          peak
);

  logic signed [FiltBits-1:0]   filt;
  logic signed [SampleBits-1:0] prev;
  logic signed [FiltBits:0]     d1;
  logic [SqBits-1:0]            prod;
  logic                         same_sign;
  logic                         d0_take;

  logic signed [FiltBits+1:0]   s_sum;
  logic signed [63:0]           p_full;
  logic signed [SampleBits:0]   dx;
  logic [StepBits-1:0]          dx_mag;
  logic signed [63:0]           q_signed;
  logic signed [63:0]           a1_full;
  logic signed [FiltBits-1:0]   a1;
  logic [FiltBits:0]            m0;
  logic [FiltBits:0]            m1;
  logic [SqBits:0]              acc;
  logic signed [FiltBits:0]     d0_now;

  // filter arithmetic, floor shift with half added
  always_comb begin
    s_sum = (FiltBits+2)'(filt) + (FiltBits+2)'(x) - (FiltBits+2)'(prev);
    p_full = 64'(s_sum) * $signed({1'b0, coef}) + 64'sd32768;
    dx = (SampleBits+1)'(x) - (SampleBits+1)'(prev);
    dx_mag = dx[SampleBits] ? StepBits'(-dx) : StepBits'(dx);
    q_signed = diff[FiltBits] ? -$signed({1'b0, quot[62:0]}) : $signed({1'b0, quot[62:0]});
    a1_full = 64'(mean) + q_signed;
    a1 = sat32(a1_full);
    m0 = diff[FiltBits] ? (FiltBits+1)'(-diff) : (FiltBits+1)'(diff);
    m1 = d1[FiltBits] ? (FiltBits+1)'(-d1) : (FiltBits+1)'(d1);
    acc = {1'b0, sq_sum} + {1'b0, prod};
    d0_now = (FiltBits+1)'(filt) - (FiltBits+1)'(mean);
  end

  // per axis statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0; prev <= '0; mean <= '0; sq_sum <= '0; peak <= '0;
      diff <= '0; d1 <= '0; prod <= '0; same_sign <= 1'b0; d0_take <= 1'b0;
    end else begin
      d0_take <= ctrl.filt;
      if (ctrl.load && ctrl.restart) begin
        mean <= '0; sq_sum <= '0; peak <= '0;
      end
      if (ctrl.filt) begin
        if (ctrl.first) begin
          filt <= FiltBits'(x);
        end else begin
          filt <= sat32(p_full >>> 16);
          if (dx_mag > peak) peak <= dx_mag;
        end
        prev <= x;
      end
      // deviation from the old mean, taken once the filter has settled
      if (d0_take) diff <= d0_now;
      if (ctrl.mean_upd) begin
        mean <= a1;
        d1 <= (FiltBits+1)'(filt) - (FiltBits+1)'(a1);
      end
      if (ctrl.sq_mul) begin
        same_sign <= (diff[FiltBits] == d1[FiltBits]);
        prod <= SqBits'(m0) * SqBits'(m1);
      end
      if (ctrl.sq_acc && same_sign) begin
        sq_sum <= acc[SqBits] ? '1 : acc[SqBits-1:0];
      end
    end
  end

endmodule

// File: rtl/hprms_divroot.sv
module hprms_divroot import hprms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start_div,
  input  logic              start_root,
  input  logic [SqBits-1:0] num,
  input  logic [CountBits-1:0] den,
  output logic              busy,
  output logic [SqBits-1:0] result
);

  logic [SqBits-1:0]     work;
  logic [SqBits-1:0]     quo;
  logic [CountBits:0]    rem;
  logic [SqBits-1:0]     r;
  logic [SqBits-1:0]     bit_v;
  logic [StepCntBits-1:0] steps;
  logic                  is_root;
  logic [CountBits:0]    rem_sh;

  assign rem_sh = {rem[CountBits-1:0], work[SqBits-1]};

  // restoring divide one bit per cycle, or root two bits per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; steps <= '0; is_root <= 1'b0;
      work <= '0; quo <= '0; rem <= '0; r <= '0; bit_v <= '0; result <= '0;
    end else if (start_div) begin
      busy <= 1'b1; is_root <= 1'b0; steps <= StepCntBits'(DivSteps);
      work <= num; quo <= '0; rem <= '0;
    end else if (start_root) begin
      busy <= 1'b1; is_root <= 1'b1; steps <= StepCntBits'(RootSteps);
      work <= num; r <= '0; bit_v <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (!is_root) begin
        work <= work << 1;
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den}; quo <= {quo[SqBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh; quo <= {quo[SqBits-2:0], 1'b0};
        end
        if (steps == StepCntBits'(1)) begin
          busy <= 1'b0;
          result <= (rem_sh >= {1'b0, den}) ? {quo[SqBits-2:0], 1'b1} : {quo[SqBits-2:0], 1'b0};
        end
      end else begin
        if (work >= r + bit_v) begin
          work <= work - (r + bit_v); r <= (r >> 1) + bit_v;
        end else begin
          r <= r >> 1;
        end
        bit_v <= bit_v >> 2;
        if (steps == StepCntBits'(1)) begin
          busy <= 1'b0;
          result <= (work >= r + bit_v) ? (r >> 1) + bit_v : r >> 1;
        end
      end
      steps <= steps - StepCntBits'(1);
    end
  end

endmodule

// File: sim/hprms_tb_if.sv
`timescale 1ns / 1ps

// the block's channel interfaces are compiled from the rtl folder; this file
// only holds the beat types shared by the testbench
package hprms_tb_pkg;
  import hprms_pkg::*;

  typedef struct packed {
    logic restart;
    logic signed [SampleBits-1:0] ra;
    logic signed [SampleBits-1:0] dec;
  } sample_beat_t;

  typedef struct packed {
    logic [CountBits-1:0] cnt;
    logic [SampleBits-1:0] ra_mean;
    logic [SampleBits-1:0] dec_mean;
    logic [SampleBits-1:0] ra_rms;
    logic [SampleBits-1:0] dec_rms;
    logic [SampleBits-1:0] tot_rms;
    logic [SampleBits-1:0] ra_step;
    logic [SampleBits-1:0] dec_step;
    logic [SampleBits-1:0] ra_p2p;
  } stats_beat_t;
endpackage

// File: sim/highpass_running_rms_two_axis_tb.sv
`timescale 1ns / 1ps

module highpass_running_rms_two_axis_tb;
  import hprms_pkg::*;
  import hprms_tb_pkg::*;

  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;
  localparam longint SMAX = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint UMAX = (64'sd1 <<< SampleBits) - 1;
  localparam longint CMAX = (64'sd1 <<< CountBits) - 1;
  localparam int NRAND = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hprms_in_if  in_ch ();
  hprms_out_if out_ch ();
  hprms_cfg_if cfg_ch ();

  highpass_running_rms_two_axis u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source),
    .cfg (cfg_ch.sink)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [CoefBits-1:0] alpha_q16;
  longint unsigned n_samples;
  longint filt_val [2];
  longint prev_raw [2];
  longint mean_val [2];
  longint unsigned sq_sum [2];
  longint unsigned peak [2];
  longint ra_lo, ra_hi;

  sample_beat_t pending_samples [$];
  stats_beat_t expected_stats [$];
  int errors = 0;
  int hold_off = 0;
  bit stim_done = 0;
  bit stall_req = 0;
  bit stall_seen = 0;
  int long_hold = 0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    return (a > ~64'd0 - b) ? ~64'd0 : a + b;
  endfunction

  function automatic longint unsigned usat(longint unsigned v);
    return v > UMAX ? UMAX : v;
  endfunction

  task automatic clear_stats();
    n_samples = 0;
    for (int i = 0; i < 2; i++) begin
      mean_val[i] = 0;
      sq_sum[i] = 0;
      peak[i] = 0;
    end
    ra_lo = 0;
    ra_hi = 0;
  endtask

  // advance the statistics by one sample and queue the expected beat
  task automatic predict_stats(sample_beat_t s);
    longint x [2];
    longint unsigned rms [2];
    longint sm, p, d0, d1, a1, q;
    longint unsigned m0, m1, prod;
    bit first;
    stats_beat_t e;
    if (s.restart) clear_stats();
    x[0] = s.ra;
    x[1] = s.dec;
    first = (n_samples == 0);
    for (int i = 0; i < 2; i++) begin
      if (first) filt_val[i] = x[i];
      else begin
        sm = filt_val[i] + x[i] - prev_raw[i];
        p = sm * longint'(alpha_q16) + 32768;
        filt_val[i] = clamp64(p >>> 16, S32MIN, S32MAX);
        if (magn(x[i] - prev_raw[i]) > peak[i]) peak[i] = magn(x[i] - prev_raw[i]);
      end
      prev_raw[i] = x[i];
    end
    if (n_samples < CMAX) n_samples++;
    for (int i = 0; i < 2; i++) begin
      d0 = filt_val[i] - mean_val[i];
      q = (magn(d0) + n_samples / 2) / n_samples;
      if (d0 < 0) q = -q;
      a1 = clamp64(mean_val[i] + q, S32MIN, S32MAX);
      d1 = filt_val[i] - a1;
      mean_val[i] = a1;
      if ((d0 < 0) == (d1 < 0)) begin
        m0 = magn(d0);
        m1 = magn(d1);
        if (m0 != 0 && m1 > ~64'd0 / m0) prod = ~64'd0;
        else prod = m0 * m1;
        sq_sum[i] = sat_sum(sq_sum[i], prod);
      end
      rms[i] = usat(int_sqrt(sq_sum[i] / n_samples));
    end
    if (first) begin
      ra_lo = x[0];
      ra_hi = x[0];
    end else begin
      if (x[0] < ra_lo) ra_lo = x[0];
      if (x[0] > ra_hi) ra_hi = x[0];
    end
    e.cnt = CountBits'(n_samples);
    e.ra_mean = SampleBits'(clamp64(mean_val[0], -SMAX - 1, SMAX));
    e.dec_mean = SampleBits'(clamp64(mean_val[1], -SMAX - 1, SMAX));
    e.ra_rms = SampleBits'(rms[0]);
    e.dec_rms = SampleBits'(rms[1]);
    e.tot_rms = SampleBits'(usat(int_sqrt(sat_sum(rms[0] * rms[0], rms[1] * rms[1]))));
    e.ra_step = SampleBits'(usat(peak[0]));
    e.dec_step = SampleBits'(usat(peak[1]));
    e.ra_p2p = SampleBits'(usat(ra_hi - ra_lo));
    expected_stats.push_back(e);
  endtask

  // sample driver with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.restart <= 1'b0;
      in_ch.ra_sample <= '0;
      in_ch.dec_sample <= '0;
      clear_stats();
      for (int i = 0; i < 2; i++) begin
        filt_val[i] = 0;
        prev_raw[i] = 0;
      end
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_stats({in_ch.restart, in_ch.ra_sample, in_ch.dec_sample});
      if (send_gap > 0 || pending_samples.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        sample_beat_t s;
        s = pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.restart <= s.restart;
        in_ch.ra_sample <= s.ra;
        in_ch.dec_sample <= s.dec;
        send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 400)
                 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
      end
    end
  end

  // long receiver stall, counted on its own
  always @(posedge clk) begin
    if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      long_hold <= 3000;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        stats_beat_t a, e;
        a = {out_ch.sample_count, out_ch.ra_hp_mean, out_ch.dec_hp_mean, out_ch.ra_rms,
             out_ch.dec_rms, out_ch.total_rms, out_ch.ra_peak_step, out_ch.dec_peak_step,
             out_ch.ra_peak_to_peak};
        if (expected_stats.size() == 0) begin
          $display("%0t unexpected beat: actual %p", $time, a);
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (a !== e) begin
            $display("%0t mismatch: expected %p actual %p", $time, e, a);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        hold_off = $urandom_range(1, 600);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_alpha(logic [CoefBits-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    alpha_q16 = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_stats.size() != 0);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic signed [SampleBits-1:0] rand_sample(int mode);
    case (mode)
      0: return SampleBits'($urandom);
      1: return SampleBits'($signed($urandom_range(0, 2000)) - 1000);
      default: return SampleBits'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic add_sample(bit r, longint ra, longint dec);
    sample_beat_t s;
    s.restart = r;
    s.ra = SampleBits'(ra);
    s.dec = SampleBits'(dec);
    pending_samples.push_back(s);
  endtask

  // stimulus
  initial begin
    logic [CoefBits-1:0] alphas [5];
    int mode;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    alpha_q16 = CoefReset;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, restart, full-scale steps
    add_sample(0, 0, 0);
    add_sample(0, -(SMAX + 1), SMAX);
    add_sample(0, SMAX, -(SMAX + 1));
    add_sample(0, -(SMAX + 1), SMAX);
    add_sample(0, -1, 1);
    add_sample(1, SMAX, SMAX);
    add_sample(0, SMAX, SMAX);
    add_sample(1, -(SMAX + 1), -(SMAX + 1));
    add_sample(0, SMAX, SMAX);
    add_sample(0, 24'sh555555, -24'sh2aaaab);
    add_sample(1, 0, 0);
    add_sample(0, 65536, -65536);
    wait_drained();

    // receiver long stall while the sender keeps offering
    stall_req = 1'b1;
    for (int i = 0; i < 6; i++) add_sample(0, rand_sample(2), rand_sample(2));
    wait_drained();

    alphas = '{16'd0, 16'hffff, 16'd1, 16'd65000, CoefReset};
    for (int ph = 0; ph < 5; ph++) begin
      write_alpha(ph == 4 ? CoefBits'($urandom) : alphas[ph]);
      for (int i = 0; i < NRAND / 5; i++) begin
        mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
        add_sample($urandom_range(0, 30) == 0, rand_sample(mode), rand_sample(mode));
      end
      wait_drained();
    end
    write_alpha(CoefReset);
    stim_done = 1;
  end

  // final verdict
  initial begin
    wait (stim_done);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // timeout: ~1770 beats, each with its processing time and any receiver stall
  initial begin
    #60000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: highpass_running_rms_two_axis.f
+incdir+rtl
rtl/hprms_pkg.sv
rtl/hprms_if.sv
rtl/hprms_lane.sv
rtl/hprms_divroot.sv
rtl/highpass_running_rms_two_axis.sv
sim/hprms_tb_if.sv
sim/highpass_running_rms_two_axis_tb.sv
